// ----- hdl/osc_pkg.sv -----
package osc_pkg;

   // field widths
   localparam int NOTE_W     = 24;
   localparam int LFO_W      = 16;
   localparam int PITCH_W    = 24;
   localparam int PPH_W      = 20;
   localparam int PW_W       = 16;
   localparam int GAIN_W     = 16;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   // phase and sample formats
   localparam int PHASE_BITS  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int PHASE_FRAC  = 48 - PHASE_BITS;

   // frequency is q16.16 hertz, never negative after clamping
   localparam int HZ_FRAC = 16;
   localparam int HZ_W    = PITCH_W + NOTE_W - HZ_FRAC;
   localparam int FREQ_W  = HZ_W + 1;

   // effective pulse width, 0 to 2^PW_W
   localparam int PWE_W = PW_W + 1;

   // serial multiplier geometry
   localparam int MUL_A_W   = FREQ_W;
   localparam int MUL_B_W   = 24;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 2;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // sine quarter table
   localparam int SINE_DEPTH      = 256;
   localparam int SINE_DEPTH_LOG2 = $clog2(SINE_DEPTH);
   localparam int SINE_IDX_W      = $clog2(SINE_DEPTH + 1);
   localparam int SINE_VAL_W      = SAMPLE_BITS - 1;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAVE_SELECT   = 3'd0,
      CSR_PITCH_SCALE   = 3'd1,
      CSR_PHASE_PER_HZ  = 3'd2,
      CSR_PULSE_WIDTH   = 3'd3,
      CSR_LFO_ENABLE    = 3'd4,
      CSR_LFO_FREQ_GAIN = 3'd5,
      CSR_LFO_PW_GAIN   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      WAVE_SAW      = 2'd0,
      WAVE_TRIANGLE = 2'd1,
      WAVE_PULSE    = 2'd2,
      WAVE_SINE     = 2'd3
   } wave_type;

   typedef struct packed {
      logic start;
      logic b_signed;
   } mul_ctl_type;

   typedef logic [SINE_DEPTH:0][SINE_VAL_W-1:0] sine_rom_type;

   // elaboration-time table build
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SINE_MAX    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam logic [5:0][7:0] TAYLOR_DIV = {8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      logic [63:0] x;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] e;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
         term = x;
         sum  = signed'(x);
         for (int j = 1; j <= 6; j++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[j-1];
            if ((j % 2) == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         e = (64'(sum) * SINE_MAX + (64'd1 << 29)) >> 30;
         if (e > SINE_MAX) begin
            e = SINE_MAX;
         end
         rom[k] = e[SINE_VAL_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

endpackage

// ----- hdl/osc_smul.sv -----
// radix-2 shift-add multiplier, multiplier bits consumed lsb first
module osc_smul
   import osc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  mul_ctl_type                 ctl,
   input  logic [MUL_A_W-1:0]          mul_a,
   input  logic [MUL_B_W-1:0]          mul_b,
   output logic signed [MUL_P_W-1:0]   product,
   output logic                        done
);

   localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_B_W - 1);

   logic                      busy_ff;
   logic                      done_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic [MUL_A_W-1:0]        a_ff;
   logic                      neg_ff;
   logic signed [MUL_A_W+1:0] hi_ff;
   logic [MUL_B_W-1:0]        lo_ff;

   logic signed [MUL_A_W+1:0] a_ext;
   logic signed [MUL_A_W+1:0] addend;
   logic signed [MUL_A_W+1:0] sum;
   logic signed [MUL_A_W+1:0] hi_in;
   logic [MUL_B_W-1:0]        lo_in;

   always_comb begin
      a_ext = signed'({2'b00, a_ff});
      // top multiplier bit carries negative weight for signed operands
      if (!lo_ff[0]) begin
         addend = '0;
      end else if (neg_ff && (cnt_ff == CNT_LAST)) begin
         addend = -a_ext;
      end else begin
         addend = a_ext;
      end
      sum   = hi_ff + addend;
      hi_in = sum >>> 1;
      lo_in = {sum[0], lo_ff[MUL_B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff   <= mul_a;
         neg_ff <= ctl.b_signed;
         hi_ff  <= '0;
         lo_ff  <= mul_b;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end

      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // one-cycle pulse after the last step
         done_ff <= busy_ff && !ctl.start && (cnt_ff == CNT_LAST);
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign product = signed'({hi_ff, lo_ff});
   assign done    = done_ff;

endmodule

// ----- hdl/multi_waveform_oscillator.sv -----
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_note_ratio, req_lfo_value
// rsp       out        rsp_valid / rsp_ready  rsp_sample
// csr       in         csr_we                 csr_index, csr_wdata
//
// each transaction makes two passes through the bit-serial multipliers
// (note, lfo terms in parallel, then phase step) plus setup and wrap-up
// states
// synchronous active-high reset clears phase and handshake, resets config
// a finished sample waits in the rsp register; the next req transaction is
// taken meanwhile and only its S_FINISH state waits for the rsp slot
module multi_waveform_oscillator
   import osc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [NOTE_W-1:0]             req_note_ratio,
   input  logic signed [LFO_W-1:0]       req_lfo_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   // register reset values
   localparam logic [PITCH_W-1:0] PITCH_RST = PITCH_W'(65536);
   localparam logic [PPH_W-1:0]   PPH_RST   = PPH_W'(97391);
   localparam logic [PW_W-1:0]    PW_RST    = PW_W'(32768);

   localparam logic [PWE_W-1:0]   PW_FULL   = PWE_W'(1 << PW_W);
   localparam int                 PWS_W     = FREQ_W - LFO_W + 1;
   localparam logic [SAMPLE_BITS-1:0] TRI_PEAK = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_START,
      S_MUL_WAIT,
      S_STEP_START,
      S_STEP_WAIT,
      S_FINISH
   } state_type;

   // configuration registers
   wave_type            wave_ff;
   logic [PITCH_W-1:0]  pitch_ff;
   logic [PPH_W-1:0]    pph_ff;
   logic [PW_W-1:0]     pw_ff;
   logic                lfo_en_ff;
   logic [GAIN_W-1:0]   fgain_ff;
   logic [GAIN_W-1:0]   pwgain_ff;

   // datapath state
   state_type                      state_ff;
   logic [NOTE_W-1:0]              note_ff;
   logic signed [LFO_W-1:0]        lfo_ff;
   logic [FREQ_W-1:0]              freq_ff;
   logic [FREQ_W-1:0]              freq_in;
   logic [PWE_W-1:0]               pwe_ff;
   logic [PWE_W-1:0]               pwe_in;
   logic [PHASE_BITS-1:0]          phase_ff;
   logic [PHASE_BITS-1:0]          phase_in;
   logic                           rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]         rsp_sample_ff;
   logic [SAMPLE_BITS-1:0]         sample_in;

   // multiplier hookup
   mul_ctl_type                ctl0, ctl1, ctl2;
   logic [MUL_A_W-1:0]         a0, a1, a2;
   logic [MUL_B_W-1:0]         b0, b_lfo;
   logic signed [MUL_P_W-1:0]  prod0, prod1, prod2;
   logic                       done0, done1, done2;

   // frequency and pulse width arithmetic
   logic [HZ_W-1:0]            note_hz;
   logic signed [FREQ_W+1:0]   lfo_hz;
   logic signed [FREQ_W+1:0]   freq_sum;
   logic signed [PWS_W-1:0]    pw_shift;
   logic signed [PWE_W+1:0]    pw_sum;

   // waveform terms
   logic [SAMPLE_BITS:0]       tri_u;
   logic [SAMPLE_BITS:0]       tri_d;
   logic [SAMPLE_BITS-1:0]     tri_val;
   logic [1:0]                 quad;
   logic [SINE_DEPTH_LOG2-1:0] sine_frac;
   logic [SINE_IDX_W-1:0]      sine_idx;
   logic [SINE_VAL_W-1:0]      sine_mag;
   logic [SAMPLE_BITS-1:0]     sine_val;

   // ---------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff   <= WAVE_SAW;
         pitch_ff  <= PITCH_RST;
         pph_ff    <= PPH_RST;
         pw_ff     <= PW_RST;
         lfo_en_ff <= 1'b0;
         fgain_ff  <= '0;
         pwgain_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WAVE_SELECT:   wave_ff   <= wave_type'(csr_wdata[1:0]);
            CSR_PITCH_SCALE:   pitch_ff  <= csr_wdata[PITCH_W-1:0];
            CSR_PHASE_PER_HZ:  pph_ff    <= csr_wdata[PPH_W-1:0];
            CSR_PULSE_WIDTH:   pw_ff     <= csr_wdata[PW_W-1:0];
            CSR_LFO_ENABLE:    lfo_en_ff <= csr_wdata[0];
            CSR_LFO_FREQ_GAIN: fgain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_LFO_PW_GAIN:   pwgain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // serial multipliers
   // unit 0: pitch * note, later freq * phase_per_hz
   // unit 1: lfo_freq_gain * lfo, unit 2: lfo_pw_gain * lfo
   // ---------------------------------------------------------------
   assign b_lfo = {{(MUL_B_W-LFO_W){lfo_ff[LFO_W-1]}}, lfo_ff};

   always_comb begin
      ctl0.start    = (state_ff == S_MUL_START) || (state_ff == S_STEP_START);
      ctl0.b_signed = 1'b0;
      ctl1.start    = (state_ff == S_MUL_START);
      ctl1.b_signed = 1'b1;
      ctl2          = ctl1;
      if (state_ff == S_STEP_START) begin
         a0 = freq_ff;
         b0 = MUL_B_W'(pph_ff);
      end else begin
         a0 = MUL_A_W'(pitch_ff);
         b0 = MUL_B_W'(note_ff);
      end
      a1 = MUL_A_W'(fgain_ff);
      a2 = MUL_A_W'(pwgain_ff);
   end

   osc_smul u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl0),
      .mul_a   (a0),
      .mul_b   (b0),
      .product (prod0),
      .done    (done0)
   );

   osc_smul u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl1),
      .mul_a   (a1),
      .mul_b   (b_lfo),
      .product (prod1),
      .done    (done1)
   );

   osc_smul u_mul2 (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl2),
      .mul_a   (a2),
      .mul_b   (b_lfo),
      .product (prod2),
      .done    (done2)
   );

   // ---------------------------------------------------------------
   // frequency: note term + doubled lfo term if on, held at zero from below
   // ---------------------------------------------------------------
   always_comb begin
      note_hz = prod0[HZ_FRAC+HZ_W-1:HZ_FRAC];
      if (lfo_en_ff) begin
         lfo_hz = {prod1[FREQ_W-1], prod1[FREQ_W-1:0], 1'b0};
      end else begin
         lfo_hz = '0;
      end
      freq_sum = signed'({{(FREQ_W+2-HZ_W){1'b0}}, note_hz}) + lfo_hz;
      if (freq_sum[FREQ_W+1]) begin
         freq_in = '0;
      end else begin
         freq_in = freq_sum[FREQ_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // effective pw: pw+floor(gain*lfo/2^15) if lfo on, clamped to full range
   // ---------------------------------------------------------------
   always_comb begin
      pw_shift = signed'(prod2[FREQ_W-1:LFO_W-1]);
      if (lfo_en_ff) begin
         pw_sum = signed'({2'b00, PWE_W'(pw_ff)})
                  + signed'({{(PWE_W+2-PWS_W){pw_shift[PWS_W-1]}}, pw_shift});
      end else begin
         pw_sum = signed'({2'b00, PWE_W'(pw_ff)});
      end
      if (pw_sum[PWE_W+1]) begin
         pwe_in = '0;
      end else if (pw_sum[PWE_W:0] > {1'b0, PW_FULL}) begin
         pwe_in = PW_FULL;
      end else begin
         pwe_in = pw_sum[PWE_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // waveform from the phase before this transaction's step
   // ---------------------------------------------------------------
   always_comb begin
      // triangle: peak at half cycle saturates to max
      tri_u = phase_ff[PHASE_BITS-1 -: SAMPLE_BITS+1];
      if (tri_u[SAMPLE_BITS]) begin
         tri_d = {1'b0, tri_u[SAMPLE_BITS-1:0]};
      end else begin
         tri_d = (SAMPLE_BITS+1)'(1 << SAMPLE_BITS) - {1'b0, tri_u[SAMPLE_BITS-1:0]};
      end
      if (tri_d == '0) begin
         tri_val = SAMPLE_MAX;
      end else begin
         tri_val = TRI_PEAK - tri_d[SAMPLE_BITS-1:0];
      end

      // sine: quadrant select, mirrored index in odd quadrants
      quad      = phase_ff[PHASE_BITS-1 -: 2];
      sine_frac = phase_ff[PHASE_BITS-3 -: SINE_DEPTH_LOG2];
      if (quad[0]) begin
         sine_idx = SINE_IDX_W'(SINE_DEPTH) - {1'b0, sine_frac};
      end else begin
         sine_idx = {1'b0, sine_frac};
      end
      sine_mag = SINE_ROM[sine_idx];
      if (quad[1]) begin
         sine_val = -{1'b0, sine_mag};
      end else begin
         sine_val = {1'b0, sine_mag};
      end

      case (wave_ff)
         WAVE_SAW: begin
            sample_in = {~phase_ff[PHASE_BITS-1],
                         phase_ff[PHASE_BITS-2 -: SAMPLE_BITS-1]};
         end
         WAVE_TRIANGLE: sample_in = tri_val;
         WAVE_PULSE: begin
            if ({1'b0, phase_ff[PHASE_BITS-1 -: PW_W]} < pwe_ff) begin
               sample_in = SAMPLE_MAX;
            end else begin
               sample_in = SAMPLE_MIN;
            end
         end
         WAVE_SINE: sample_in = sine_val;
         default:   sample_in = sine_val;
      endcase
   end

   // phase step is the q16.16 frequency times phase_per_hz, fraction dropped
   assign phase_in = phase_ff + prod0[PHASE_FRAC+PHASE_BITS-1:PHASE_FRAC];

   // ---------------------------------------------------------------
   // sequencer and output register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      // payload, no reset needed
      if ((state_ff == S_IDLE) && req_valid) begin
         note_ff <= req_note_ratio;
         lfo_ff  <= req_lfo_value;
      end
      if ((state_ff == S_MUL_WAIT) && done0 && done1 && done2) begin
         freq_ff <= freq_in;
         pwe_ff  <= pwe_in;
      end
      if ((state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_sample_ff <= sample_in;
      end

      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         // result taken downstream and no new one replacing it
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_MUL_START;
               end
            end
            S_MUL_START: state_ff <= S_MUL_WAIT;
            S_MUL_WAIT: begin
               if (done0 && done1 && done2) begin
                  state_ff <= S_STEP_START;
               end
            end
            S_STEP_START: state_ff <= S_STEP_WAIT;
            S_STEP_WAIT: begin
               if (done0) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // wait for a free output slot, then publish and step phase
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  phase_ff     <= phase_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = signed'(rsp_sample_ff);

endmodule

// ----- hdl/osc_chk.sv -----
module osc_chk
   import osc_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("rsp transaction changed while stalled");

   // reset empties the output register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // an accepted transaction makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready still high after accepted transaction");

   // a new result only comes out of the busy phase
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("rsp_valid rose while block was idle");

endmodule

bind multi_waveform_oscillator osc_chk u_osc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);
